// ===== sv/euler_to_quaternion_defines.svh =====
// Assertion helpers
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define E2Q_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2Q_ASSERT(label, clk, rst_n, prop, msg)
`define E2Q_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== sv/e2q_pkg.sv =====
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int ANGLE_W = 16;
    localparam int QUAT_W  = 16;
    localparam int CW      = 34;   // CORDIC datapath, Q30 with headroom
    localparam int SC_W    = 22;   // Q20 sine and cosine
    localparam int ATAN_N  = 24;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [QUAT_W-1:0] Q14_ONE = 16'sd16384;

    typedef logic signed [CW-1:0]   cw_t;
    typedef logic signed [SC_W-1:0] sc_t;

    function automatic cw_t atan_q30(input logic [4:0] i);
        cw_t r;
        r = '0;
        case (i)
            5'd0:  r = 34'sh03243F6A8;
            5'd1:  r = 34'sh01DAC6705;
            5'd2:  r = 34'sh00FADBAFC;
            5'd3:  r = 34'sh007F56EA6;
            5'd4:  r = 34'sh003FEAB76;
            5'd5:  r = 34'sh001FFD55B;
            5'd6:  r = 34'sh000FFFAAA;
            5'd7:  r = 34'sh0007FFF55;
            5'd8:  r = 34'sh0003FFFEA;
            5'd9:  r = 34'sh0001FFFFD;
            5'd10: r = 34'sh0000FFFFF;
            5'd11: r = 34'sh00007FFFF;
            5'd12: r = 34'sh00003FFFF;
            5'd13: r = 34'sh00001FFFF;
            5'd14: r = 34'sh00000FFFF;
            5'd15: r = 34'sh000007FFF;
            5'd16: r = 34'sh000003FFF;
            5'd17: r = 34'sh000001FFF;
            5'd18: r = 34'sh000000FFF;
            5'd19: r = 34'sh0000007FF;
            5'd20: r = 34'sh0000003FF;
            5'd21: r = 34'sh0000001FF;
            5'd22: r = 34'sh0000000FF;
            5'd23: r = 34'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// ===== sv/e2q_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined half-angle sine/cosine: fold stage, one register per iteration,
// rounding stage. Enable advances the whole chain together.
module e2q_cordic #(
    parameter int STAGES = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [15:0]         angle,
    output e2q_pkg::sc_t               cos_q20,
    output e2q_pkg::sc_t               sin_q20
);
    import e2q_pkg::*;

    localparam int N = (STAGES < ATAN_N) ? STAGES : ATAN_N;

    cw_t x_reg [0:N];
    cw_t y_reg [0:N];
    cw_t z_reg [0:N];
    logic flip_reg [0:N];
    sc_t cos_reg, sin_reg;

    cw_t z0, zf;
    logic fl;
    always_comb
    begin
        z0 = {{(CW-32){angle[15]}}, angle, 16'd0};
        zf = z0;
        fl = 1'b0;
        if (z0 > HALF_PI_Q30)
        begin
            zf = z0 - PI_Q30;
            fl = 1'b1;
        end
        else if (z0 < -HALF_PI_Q30)
        begin
            zf = z0 + PI_Q30;
            fl = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= zf;
            flip_reg[0] <= fl;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        cw_t dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q30(5'(i));
                end
            end
        end
    end

    cw_t xo, yo, xr, yr;
    always_comb
    begin
        xo = flip_reg[N] ? -x_reg[N] : x_reg[N];
        yo = flip_reg[N] ? -y_reg[N] : y_reg[N];
        xr = (xo + cw_t'(512)) >>> 10;
        yr = (yo + cw_t'(512)) >>> 10;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= xr[SC_W-1:0];
            sin_reg <= yr[SC_W-1:0];
        end
    end

    assign cos_q20 = cos_reg;
    assign sin_q20 = sin_reg;
endmodule

// ===== sv/euler_to_quaternion.sv =====
`timescale 1ns / 1ps
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// input    | in_valid in_ready angle_x/y/z    | in
// output   | out_valid out_ready quat_w/x/y/z | out
//
// One beat enters per cycle while the output is not stalled; the pipeline
// has one register per CORDIC iteration (at most 24 used) plus fold,
// round, two product stages, sum and saturate stages. Reset clears only
// the valid bits. A stall at the output freezes the whole pipeline;
// in_ready is low only while the last stage holds a beat that is not taken.
`include "euler_to_quaternion_defines.svh"
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z
);
    import e2q_pkg::*;

    localparam int N   = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int LAT = N + 6;
    localparam int PW  = 2 * SC_W;      // Q40 partial products
    localparam int TW  = 3 * SC_W;      // Q60 triple products
    localparam int SW  = TW + 1;

    logic en;
    logic [LAT-1:0] vld_reg;

    assign en = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    sc_t cx, sx, cy, sy, cz, sz;
    e2q_cordic #(.STAGES(N)) u_cx (.clk(clk), .en(en), .angle(angle_x),
        .cos_q20(cx), .sin_q20(sx));
    e2q_cordic #(.STAGES(N)) u_cy (.clk(clk), .en(en), .angle(angle_y),
        .cos_q20(cy), .sin_q20(sy));
    e2q_cordic #(.STAGES(N)) u_cz (.clk(clk), .en(en), .angle(angle_z),
        .cos_q20(cz), .sin_q20(sz));

    // pair products, carry the third factor alongside
    logic signed [PW-1:0] cycx_reg, sysx_reg, cysx_reg, sycx_reg;
    sc_t cz_reg, sz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycx_reg <= PW'(cy * cx);
            sysx_reg <= PW'(sy * sx);
            cysx_reg <= PW'(cy * sx);
            sycx_reg <= PW'(sy * cx);
            cz_reg <= cz;
            sz_reg <= sz;
        end
    end

    logic signed [TW-1:0] t_reg [0:7];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= TW'(cycx_reg * cz_reg);
            t_reg[1] <= TW'(sysx_reg * sz_reg);
            t_reg[2] <= TW'(cysx_reg * cz_reg);
            t_reg[3] <= TW'(sycx_reg * sz_reg);
            t_reg[4] <= TW'(sycx_reg * cz_reg);
            t_reg[5] <= TW'(cysx_reg * sz_reg);
            t_reg[6] <= TW'(cycx_reg * sz_reg);
            t_reg[7] <= TW'(sysx_reg * cz_reg);
        end
    end

    logic signed [SW-1:0] s_reg [0:3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= SW'(t_reg[0]) + SW'(t_reg[1]);
            s_reg[1] <= SW'(t_reg[2]) + SW'(t_reg[3]);
            s_reg[2] <= SW'(t_reg[4]) - SW'(t_reg[5]);
            s_reg[3] <= SW'(t_reg[6]) - SW'(t_reg[7]);
        end
    end

    logic signed [QUAT_W-1:0] q_reg [0:3];
    for (genvar k = 0; k < 4; k++)
    begin : g_sat
        logic signed [SW-1:0] r;
        logic signed [QUAT_W-1:0] q;
        always_comb
        begin
            r = (s_reg[k] + (SW'(1) <<< 45)) >>> 46;
            if (r > SW'(Q14_ONE))
                q = Q14_ONE;
            else if (r < -SW'(Q14_ONE))
                q = -Q14_ONE;
            else
                q = r[QUAT_W-1:0];
        end
        always_ff @(posedge clk)
        begin
            if (en)
                q_reg[k] <= q;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];

    `E2Q_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(quat_w), "stalled beat lost")
    `E2Q_ASSERT(a_ready, clk, rst_n, in_ready == (!out_valid || out_ready), "ready mismatch")
    `E2Q_ASSERT(a_range, clk, rst_n, out_valid |-> (quat_x <= Q14_ONE && quat_x >= -Q14_ONE), "quat_x out of range")
    `E2Q_ASSERT_RST(a_reset, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule

// ===== test/quat_checker.sv =====
`timescale 1ns / 1ps
module quat_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output int                 errors,
    output int                 pending
);
    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    quat_t quat_fifo[$];
    int err_cnt = 0;

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tbl[i];
    endfunction

    // cosine and sine of half the angle, Q20
    function automatic void half_cos_sin(input logic signed [15:0] ang,
                                         output longint c, output longint s);
        longint zz, xx, yy, dx, dy;
        bit flip;
        zz = longint'(ang) * 65536;
        xx = 652032874;
        yy = 0;
        flip = 0;
        if (zz > 64'sd1686629713) begin
            zz -= 64'sd3373259426;
            flip = 1;
        end
        else if (zz < -64'sd1686629713) begin
            zz += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = asr64(yy, i);
            dy = asr64(xx, i);
            if (zz >= 0) begin
                xx -= dx;
                yy += dy;
                zz -= atan_entry(i);
            end
            else begin
                xx += dx;
                yy -= dy;
                zz += atan_entry(i);
            end
        end
        if (flip) begin
            xx = -xx;
            yy = -yy;
        end
        c = asr64(xx + 512, 10);
        s = asr64(yy + 512, 10);
    endfunction

    function automatic logic signed [15:0] round_sat(longint v);
        longint r;
        r = asr64(v + (64'sd1 <<< 45), 46);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic quat_t predict_quat(logic signed [15:0] ax,
                                           logic signed [15:0] ay,
                                           logic signed [15:0] az);
        longint cx, sx, cy, sy, cz, sz;
        quat_t q;
        half_cos_sin(ax, cx, sx);
        half_cos_sin(ay, cy, sy);
        half_cos_sin(az, cz, sz);
        q.w = round_sat(cy * cx * cz + sy * sx * sz);
        q.x = round_sat(cy * sx * cz + sy * cx * sz);
        q.y = round_sat(sy * cx * cz - cy * sx * sz);
        q.z = round_sat(cy * cx * sz - sy * sx * cz);
        return q;
    endfunction

    assign errors = err_cnt;

    always @(posedge clk) begin
        quat_t q;
        if (rst_n) begin
            if (in_valid && in_ready)
                quat_fifo.push_back(predict_quat(angle_x, angle_y, angle_z));
            if (out_valid && out_ready) begin
                if (quat_fifo.size() == 0) begin
                    $error("unexpected result beat");
                    err_cnt++;
                end
                else begin
                    q = quat_fifo.pop_front();
                    if (q.w !== quat_w) begin
                        $error("quat_w expected %0d actual %0d", q.w, quat_w);
                        err_cnt++;
                    end
                    if (q.x !== quat_x) begin
                        $error("quat_x expected %0d actual %0d", q.x, quat_x);
                        err_cnt++;
                    end
                    if (q.y !== quat_y) begin
                        $error("quat_y expected %0d actual %0d", q.y, quat_y);
                        err_cnt++;
                    end
                    if (q.z !== quat_z) begin
                        $error("quat_z expected %0d actual %0d", q.z, quat_z);
                        err_cnt++;
                    end
                end
            end
        end
        pending <= quat_fifo.size();
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
    localparam int N_RANDOM = 1230;
    localparam int LIMIT = 200000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] angle_x = 0, angle_y = 0, angle_z = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    int errors, pending;
    int cycles = 0;
    bit calm = 0;

    always #10 clk = ~clk;

    euler_to_quaternion u_top (.*);

    quat_checker u_chk (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: take everything while the directed beats drain, then one long
    // hold-off while random beats pile up, then random stall bursts
    initial begin
        int n;
        @(posedge rst_n);
        out_ready <= 1;
        repeat (120) @(posedge clk);
        out_ready <= 0;
        repeat (200) @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                out_ready <= 0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
        end
    end

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd12868 + $signed(16'($urandom_range(0, 6))) - 16'sd3;
            3: return -16'sd12868 + $signed(16'($urandom_range(0, 6))) - 16'sd3;
            4: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic send(input logic signed [15:0] ax, input logic signed [15:0] ay,
                        input logic signed [15:0] az);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial begin
        logic signed [15:0] edges[8] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1,
                                         16'sd12868, -16'sd12868, 16'sd25736};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, zero, near the fold points at +-pi/2 half angle
        for (int i = 0; i < 8; i++)
            send(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
        send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send(16'sh8000, 16'sh8000, 16'sh8000);
        send(16'sd25737, 16'sd25735, -16'sd25737);
        send(-16'sd25736, 16'sd12867, 16'sd12869);
        in_valid <= 0;
        @(posedge clk);
        // pause until everything is drained
        while (pending != 0) @(posedge clk);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 200) calm = 1;
            send(pick_angle(), pick_angle(), pick_angle());
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
